>>> hw/rtl/slxfr_pkg.sv
// ----------------------------------------------------------------------------
// slxfr_pkg
// Types and constants shared by the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package slxfr_pkg;

	localparam logic [7:0] START_BYTE  = 8'h55;
	localparam logic [7:0] LENGTH_BIAS = 8'd5;
	localparam logic [6:0] CMD_OFFSET  = 7'd3;
	localparam logic [6:0] TOTAL_LIMIT = 7'd127;

	localparam logic [7:0]  MAX_TOTAL_RESET = 8'd79;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd10000;

	localparam int CFG_DATA_W = 16;

	typedef enum logic {
		REG_MAX_TOTAL = 1'b0,
		REG_TIMEOUT   = 1'b1
	} reg_index_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		KIND_BODY      = 3'd0,
		KIND_FRAME     = 3'd1,
		KIND_BAD_START = 3'd2,
		KIND_BAD_LEN   = 3'd3,
		KIND_TIMEOUT   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_value;
		logic [7:0] command_code;
		logic       checksum_good;
		logic [6:0] frame_total;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [7:0]  max_total_length;
		logic [15:0] timeout_ticks;
	} cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/slxfr_stream_if.sv
// ----------------------------------------------------------------------------
// slxfr_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface slxfr_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/start_length_xor_frame_receiver.sv
// A word accepted into the input register is decoded and its result held in the result register.
// Throughput: one word per cycle; the input register, the frame decode and the
// result register advance together whenever the result register is free or drained.
// Words that cause no result still pass the pipeline.
// Reset: arst_n clears frame state to start hunting and loads the registers with
// a maximum total length of 79 and a timeout of 10000 ticks.
// ----------------------------------------------------------------------------
// start_length_xor_frame_receiver
// Length-prefixed frame receiver with XOR checksum and tick-based timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module start_length_xor_frame_receiver (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	slxfr_stream_if.sink                                item,
	slxfr_stream_if.source                              result,
	input  wire logic                                   cfg_we,
	input  wire slxfr_pkg::reg_index_t                  cfg_index,
	input  wire logic [slxfr_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import slxfr_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res;
	logic    res_valid;
	logic    advance;

	// the decode stage moves whenever the result register can take its output
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_total_length <= MAX_TOTAL_RESET;
			cfg_q.timeout_ticks    <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_TOTAL: cfg_q.max_total_length <= cfg_data[7:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks    <= cfg_data[15:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.payload;
		end
	end

	slxfr_frame_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.cfg       (cfg_q),
		.res       (res),
		.res_valid (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = res_s2;
endmodule

`default_nettype wire

>>> hw/rtl/slxfr_frame_fsm.sv
// ----------------------------------------------------------------------------
// slxfr_frame_fsm
// Frame state and per-word decode: start hunt, length check, body, checksum, tick timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_frame_fsm (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire slxfr_pkg::item_t  item_s1,
	input  wire slxfr_pkg::cfg_t   cfg,
	output slxfr_pkg::result_t     res,
	output logic                   res_valid
);
	import slxfr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] xor_q, xor_d;
	logic [6:0] seen_q, seen_d;
	logic [6:0] total_q, total_d;
	logic [7:0] cmd_q, cmd_d;
	logic [15:0] ticks_q, ticks_d;

	logic [16:0] tick_next;
	logic [8:0]  len_total;
	logic [7:0]  seen_inc;
	logic        go_hunt;
	logic [7:0]  b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			xor_q   <= '0;
			seen_q  <= '0;
			total_q <= '0;
			cmd_q   <= '0;
			ticks_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			seen_q  <= seen_d;
			total_q <= total_d;
			cmd_q   <= cmd_d;
			ticks_q <= ticks_d;
		end
	end

	assign b         = item_s1.rx_byte;
	assign tick_next = {1'b0, ticks_q} + 17'd1;
	assign len_total = {1'b0, b} + {1'b0, LENGTH_BIAS};
	assign seen_inc  = {1'b0, seen_q} + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		xor_d     = xor_q;
		seen_d    = seen_q;
		total_d   = total_q;
		cmd_d     = cmd_q;
		ticks_d   = ticks_q;
		go_hunt   = 1'b0;
		res_valid = 1'b0;
		res       = '{kind: KIND_BODY, default: '0};

		if (item_s1.operation == OP_TICK) begin
			if (phase_q != PH_HUNT) begin
				if (tick_next > {1'b0, cfg.timeout_ticks}) begin
					go_hunt   = 1'b1;
					res_valid = 1'b1;
					res.kind  = KIND_TIMEOUT;
					res.last  = 1'b1;
				end else begin
					ticks_d = tick_next[15:0];
				end
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (b != START_BYTE) begin
						res_valid      = 1'b1;
						res.kind       = KIND_BAD_START;
						res.data_value = b;
						res.last       = 1'b1;
					end else begin
						phase_d = PH_LEN;
						xor_d   = b;
						seen_d  = 7'd1;
						total_d = '0;
						cmd_d   = '0;
						ticks_d = '0;
					end
				end
				PH_LEN: begin
					if (b == 8'd0 || len_total >= {1'b0, cfg.max_total_length}
							|| len_total > {2'b00, TOTAL_LIMIT}) begin
						go_hunt        = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_BAD_LEN;
						res.data_value = b;
						res.last       = 1'b1;
					end else begin
						total_d = len_total[6:0];
						xor_d   = xor_q ^ b;
						seen_d  = 7'd2;
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					// final byte carries the checksum of everything before it
					if (seen_inc >= {1'b0, total_q}) begin
						go_hunt           = 1'b1;
						res_valid         = 1'b1;
						res.kind          = KIND_FRAME;
						res.data_value    = b;
						res.command_code  = cmd_q;
						res.checksum_good = (xor_q == b);
						res.frame_total   = total_q;
						res.last          = 1'b1;
					end else begin
						if (seen_q == CMD_OFFSET) begin
							cmd_d = b;
						end
						xor_d          = xor_q ^ b;
						seen_d         = seen_inc[6:0];
						res_valid      = 1'b1;
						res.kind       = KIND_BODY;
						res.data_value = b;
					end
				end
				default: begin
					go_hunt = 1'b1;
				end
			endcase
		end

		if (go_hunt) begin
			phase_d = PH_HUNT;
			xor_d   = '0;
			seen_d  = '0;
			total_d = '0;
			cmd_d   = '0;
			ticks_d = '0;
		end
	end
endmodule

`default_nettype wire

>>> hw/rtl/slxfr_checker.sv
// ----------------------------------------------------------------------------
// slxfr_checker
// Port-level checks on the frame receiver's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire slxfr_pkg::result_t  res_payload
);
	import slxfr_pkg::*;

	// a stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled word keeps its contents
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_payload))
		else $error("result changed while stalled");

	// only body words leave a frame attempt open
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_payload.last == (res_payload.kind != KIND_BODY)))
		else $error("last flag disagrees with kind");

	// a completed frame has at least start, length, three body and checksum bytes
	a_frame_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.kind == KIND_FRAME |-> res_payload.frame_total >= 7'd6)
		else $error("frame total too short");

	// frame-only fields stay clear on every other kind
	a_clear_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.kind != KIND_FRAME |->
			res_payload.frame_total == 7'd0 && res_payload.command_code == 8'd0
			&& !res_payload.checksum_good)
		else $error("frame fields set on non-frame result");
endmodule

bind start_length_xor_frame_receiver slxfr_checker u_slxfr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_payload (result.payload)
);

`default_nettype wire

>>> verif/tb_start_length_xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_start_length_xor_frame_receiver
// Self-checking bench for the length-prefixed frame receiver. A driver feeds
// byte and tick words from a queue, a monitor tracks frame state on every
// accepted word and checks each result word against the predicted one.
// ----------------------------------------------------------------------------

module tb_start_length_xor_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	import slxfr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_PRINTED  = 40;

	typedef struct {
		item_t word;
		bit    hold;
	} queued_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	reg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	slxfr_stream_if #(.payload_t(item_t))   item_if ();
	slxfr_stream_if #(.payload_t(result_t)) result_if ();

	start_length_xor_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Frame tracking state and register copies
	logic [7:0]  lim_total;
	logic [15:0] lim_ticks;
	phase_t      ph;
	logic [7:0]  run_xor;
	logic [6:0]  seen;
	logic [6:0]  want_total;
	logic [7:0]  cmd_byte;
	logic [15:0] tick_count;
	result_t     events_due[$];

	queued_word_t word_queue[$];
	int unsigned  send_idle_pct  = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  error_count    = 0;
	int unsigned  cycle_count    = 0;
	int unsigned  bytes_queued   = 0;
	int unsigned  cur_max;
	int unsigned  cur_tmo;
	bit           hold_next      = 1'b0;
	bit           item_taken     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(string what);
		error_count++;
		if (error_count <= MAX_PRINTED) begin
			$display("MISMATCH at %0t: %s", $realtime, what);
		end
	endtask

	task automatic check_field(string name, logic [7:0] got_v, logic [7:0] want_v);
		if (got_v !== want_v) begin
			flag_mismatch($sformatf("%s: got %0h, expected %0h", name, got_v, want_v));
		end
	endtask

	task automatic restart_hunt();
		ph         = PH_HUNT;
		run_xor    = '0;
		seen       = '0;
		want_total = '0;
		cmd_byte   = '0;
		tick_count = '0;
	endtask

	function automatic result_t make_event(kind_t k, logic [7:0] d, logic [7:0] c,
	                                       logic g, logic [6:0] t);
		result_t e;
		e.kind          = k;
		e.data_value    = d;
		e.command_code  = c;
		e.checksum_good = g;
		e.frame_total   = t;
		e.last          = (k != KIND_BODY);
		return e;
	endfunction

	// Advance the frame state by one accepted word and queue what it reports
	task automatic follow_frame(input item_t w);
		logic [16:0] next_ticks;
		logic [8:0]  total;
		logic [6:0]  frame_len;
		logic [7:0]  frame_cmd;
		logic        good;
		if (w.operation == OP_TICK) begin
			if (ph != PH_HUNT) begin
				next_ticks = {1'b0, tick_count} + 17'd1;
				if (next_ticks > {1'b0, lim_ticks}) begin
					restart_hunt();
					events_due.push_back(make_event(KIND_TIMEOUT, 8'd0, 8'd0, 1'b0, 7'd0));
				end else begin
					tick_count = next_ticks[15:0];
				end
			end
		end else begin
			case (ph)
				PH_HUNT: begin
					if (w.rx_byte != START_BYTE) begin
						events_due.push_back(make_event(KIND_BAD_START, w.rx_byte, 8'd0,
						                                1'b0, 7'd0));
					end else begin
						restart_hunt();
						ph      = PH_LEN;
						run_xor = w.rx_byte;
						seen    = 7'd1;
					end
				end
				PH_LEN: begin
					total = {1'b0, w.rx_byte} + {1'b0, LENGTH_BIAS};
					if (w.rx_byte == 8'd0 || total >= {1'b0, lim_total} ||
					    total > {2'b0, TOTAL_LIMIT}) begin
						restart_hunt();
						events_due.push_back(make_event(KIND_BAD_LEN, w.rx_byte, 8'd0,
						                                1'b0, 7'd0));
					end else begin
						want_total = total[6:0];
						run_xor    = run_xor ^ w.rx_byte;
						seen       = 7'd2;
						ph         = PH_BODY;
					end
				end
				PH_BODY: begin
					if ({1'b0, seen} + 8'd1 >= {1'b0, want_total}) begin
						good      = (run_xor == w.rx_byte);
						frame_len = want_total;
						frame_cmd = cmd_byte;
						restart_hunt();
						events_due.push_back(make_event(KIND_FRAME, w.rx_byte, frame_cmd,
						                                good, frame_len));
					end else begin
						if (seen == CMD_OFFSET) begin
							cmd_byte = w.rx_byte;
						end
						run_xor = run_xor ^ w.rx_byte;
						seen    = seen + 7'd1;
						events_due.push_back(make_event(KIND_BODY, w.rx_byte, 8'd0, 1'b0, 7'd0));
					end
				end
				default: restart_hunt();
			endcase
		end
	endtask

	// Monitor: check result words, track register writes and accepted words
	always @(posedge clk) begin : watch
		result_t got;
		result_t want;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				got = result_if.payload;
				if (events_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result kind %0d data %0h",
					                        got.kind, got.data_value));
				end else begin
					want = events_due.pop_front();
					check_field("kind", 8'(got.kind), 8'(want.kind));
					check_field("data_value", got.data_value, want.data_value);
					check_field("command_code", got.command_code, want.command_code);
					check_field("checksum_good", 8'(got.checksum_good),
					            8'(want.checksum_good));
					check_field("frame_total", 8'(got.frame_total), 8'(want.frame_total));
					check_field("last", 8'(got.last), 8'(want.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_TOTAL: lim_total = cfg_data[7:0];
					REG_TIMEOUT:   lim_ticks = cfg_data[15:0];
					default: ;
				endcase
			end
			item_taken = item_if.valid && item_if.ready;
			if (item_taken) begin
				follow_frame(item_if.payload);
			end
		end
	end

	// Driver: present the next word once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			item_if.valid   <= 1'b0;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			if (!item_if.valid || item_taken) begin
				if (word_queue.size() != 0 &&
				    !(word_queue[0].hold && events_due.size() != 0) &&
				    $urandom_range(99) >= send_idle_pct) begin
					item_if.payload <= word_queue[0].word;
					item_if.valid   <= 1'b1;
					void'(word_queue.pop_front());
				end else begin
					item_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("start_length_xor_frame_receiver test failed");
			$finish;
		end
	end

	task automatic put_byte(logic [7:0] b);
		queued_word_t q;
		q.word.operation = OP_BYTE;
		q.word.rx_byte   = b;
		q.hold           = hold_next;
		hold_next        = 1'b0;
		word_queue.push_back(q);
		bytes_queued++;
	endtask

	task automatic put_tick();
		queued_word_t q;
		q.word.operation = OP_TICK;
		q.word.rx_byte   = 8'($urandom_range(255));
		q.hold           = 1'b0;
		word_queue.push_back(q);
	endtask

	// Queue a frame; stop after the length byte when the length is rejected, or before the checksum when cut
	task automatic send_frame(int unsigned len, bit good, int unsigned tick_pct, bit cut);
		logic [7:0]  sum;
		logic [7:0]  b;
		int unsigned body;
		int unsigned n;
		put_byte(START_BYTE);
		put_byte(len[7:0]);
		sum = START_BYTE ^ len[7:0];
		if (len != 0 && len + 5 < cur_max && len + 5 <= 127) begin
			body = len + 2;
			n    = cut ? $urandom_range(body - 1) : body;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(99) < tick_pct) begin
					put_tick();
				end
				b   = 8'($urandom_range(255));
				sum = sum ^ b;
				put_byte(b);
			end
			if (!cut) begin
				put_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
			end
		end
	endtask

	task automatic fill_random(int unsigned n_bytes);
		int unsigned stop_at;
		int unsigned top;
		int unsigned small_top;
		int unsigned len;
		int unsigned k;
		stop_at   = bytes_queued + n_bytes;
		top       = (cur_max > 6) ? cur_max - 6 : 0;
		if (top > 122) begin
			top = 122;
		end
		small_top = (top < 16) ? top : 16;
		while (bytes_queued < stop_at) begin
			k = $urandom_range(99);
			if (k < 60) begin
				if (top == 0) begin
					len = $urandom_range(1, 8);
				end else if ($urandom_range(7) != 0) begin
					len = $urandom_range(1, small_top);
				end else begin
					len = $urandom_range(1, top);
				end
				send_frame(len, $urandom_range(7) != 0, 8, 1'b0);
			end else if (k < 68) begin
				case ($urandom_range(3))
					0:       len = 0;
					1:       len = top + 1;
					2:       len = top;
					default: len = $urandom_range(255);
				endcase
				send_frame(len, 1'b1, 0, 1'b0);
			end else if (k < 76) begin
				// open a frame and send ticks; it runs out of ticks only when the timeout is below 64
				put_byte(START_BYTE);
				if (top != 0 && $urandom_range(1) != 0) begin
					put_byte(8'($urandom_range(1, small_top)));
				end
				k = (cur_tmo < 64) ? cur_tmo + 1 : $urandom_range(1, 4);
				repeat (k) put_tick();
			end else if (k < 84) begin
				send_frame((top == 0) ? 1 : $urandom_range(1, small_top), 1'b1, 8, 1'b1);
			end else if (k < 94) begin
				repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 3)) put_tick();
			end
		end
	endtask

	task automatic set_regs(int unsigned max_len, int unsigned tmo);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_TOTAL;
		cfg_data  <= {8'($urandom_range(255)), 8'(max_len)};
		@(negedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= 16'(tmo);
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_max = max_len;
		cur_tmo = tmo;
	endtask

	// Wait until every queued word is taken and every result has arrived
	task automatic settle();
		while (word_queue.size() != 0 || item_if.valid || events_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_MAX_TOTAL;
		cfg_data          = '0;
		item_if.valid     = 1'b0;
		item_if.payload   = '0;
		result_if.ready   = 1'b0;
		cur_max           = MAX_TOTAL_RESET;
		cur_tmo           = TIMEOUT_RESET;
		lim_total         = MAX_TOTAL_RESET;
		lim_ticks         = TIMEOUT_RESET;
		restart_hunt();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: wrong start bytes, hunting tick, length errors, short frames
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'hAA);
		put_byte(8'h54);
		put_tick();
		send_frame(0, 1'b1, 0, 1'b0);
		send_frame(MAX_TOTAL_RESET - LENGTH_BIAS, 1'b1, 0, 1'b0);
		send_frame(255, 1'b1, 0, 1'b0);
		send_frame(1, 1'b1, 50, 1'b0);
		send_frame(2, 1'b0, 0, 1'b0);
		fill_random(350);
		settle();

		// Largest limits, longest frame, sender gaps
		set_regs(128, 65535);
		send_idle_pct = 50;
		send_frame(123, 1'b1, 0, 1'b0);
		send_frame(122, 1'b1, 0, 1'b0);
		fill_random(330);
		settle();

		// Frame length capped by the result width, zero timeout, receiver stalls
		set_regs(255, 0);
		send_idle_pct  = 0;
		recv_stall_pct = 50;
		send_frame(123, 1'b1, 0, 1'b0);
		put_byte(START_BYTE);
		put_tick();
		fill_random(150);
		settle();

		// Smallest limits: every length rejected, second tick times out
		set_regs(6, 1);
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		send_frame(1, 1'b1, 0, 1'b0);
		put_byte(START_BYTE);
		put_tick();
		put_tick();
		fill_random(150);
		settle();

		set_regs($urandom_range(6, 128), $urandom_range(1, 40));
		fill_random(350);
		settle();

		// Hold the sender once mid-stream until all results are back
		set_regs($urandom_range(6, 128), $urandom_range(1, 65535));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fill_random(150);
		hold_next = 1'b1;
		fill_random(150);
		settle();

		if (error_count == 0) begin
			$display("start_length_xor_frame_receiver test passed");
		end else begin
			$display("start_length_xor_frame_receiver test failed");
		end
		$finish;
	end

endmodule
